@@ hdl/stn_pkg.sv @@
`default_nettype none
package stn_pkg;

	// Item kinds.
	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_TICK  = 2'd1;
	localparam logic [1:0] KIND_FRAME = 2'd2;
	localparam logic [1:0] KIND_SPARE = 2'd3;

	// Decoded bus addresses.
	localparam logic [15:0] ADDR_PULSE_LO = 16'h4000;
	localparam logic [15:0] ADDR_PULSE_HI = 16'h4007;
	localparam logic [15:0] ADDR_TRI_LIN  = 16'h4008;
	localparam logic [15:0] ADDR_TRI_LO   = 16'h400a;
	localparam logic [15:0] ADDR_TRI_HI   = 16'h400b;
	localparam logic [15:0] ADDR_NOI_CTL  = 16'h400c;
	localparam logic [15:0] ADDR_NOI_PER  = 16'h400e;
	localparam logic [15:0] ADDR_NOI_LEN  = 16'h400f;
	localparam logic [15:0] ADDR_STATUS   = 16'h4015;
	localparam logic [15:0] ADDR_FRAME    = 16'h4017;

	// Pulse register offsets within a channel.
	localparam logic [1:0] PREG_CTL   = 2'd0;
	localparam logic [1:0] PREG_SWEEP = 2'd1;
	localparam logic [1:0] PREG_LO    = 2'd2;
	localparam logic [1:0] PREG_HI    = 2'd3;

	localparam logic [15:0] PERIOD_MAX = 16'h07ff;

	// Fraction bits of the mixer tables.
	localparam int FRAC_BITS = 24;

	typedef logic [31:0] frac_t;
	typedef frac_t pmix_tab_t [31];
	typedef frac_t tmix_tab_t [256];
	typedef logic [7:0] len_tab_t [32];
	typedef logic [11:0] noise_tab_t [16];
	typedef logic [7:0] duty_tab_t [4];

	localparam len_tab_t LEN_TAB = '{
		8'd10, 8'd254, 8'd20, 8'd2, 8'd40, 8'd4, 8'd80, 8'd6,
		8'd160, 8'd8, 8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
		8'd12, 8'd16, 8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
		8'd192, 8'd24, 8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30};

	localparam noise_tab_t NOISE_TAB = '{
		12'd4, 12'd8, 12'd16, 12'd32, 12'd64, 12'd96, 12'd128, 12'd160,
		12'd202, 12'd254, 12'd380, 12'd508, 12'd762, 12'd1016, 12'd2034, 12'd4068};

	localparam duty_tab_t DUTY_TAB = '{8'h02, 8'h06, 8'h1e, 8'hf9};

	typedef struct packed {
		logic       on;
		logic       loop;
		logic       start;
		logic [3:0] period;
		logic [3:0] div;
		logic [3:0] vol;
	} env_t;

	typedef struct packed {
		logic        enable;
		logic        run;
		logic [7:0]  length;
		logic [15:0] period;
		logic [15:0] timer;
		logic [1:0]  duty_mode;
		logic [2:0]  duty_step;
		logic        sw_reload;
		logic        sw_on;
		logic        sw_neg;
		logic [2:0]  sw_shift;
		logic [3:0]  sw_period;
		logic [3:0]  sw_div;
		env_t        env;
	} pulse_t;

	typedef struct packed {
		logic        enable;
		logic        run;
		logic        reload_flag;
		logic [7:0]  length;
		logic [10:0] period;
		logic [10:0] timer;
		logic [4:0]  step;
		logic [6:0]  lin_reload;
		logic [6:0]  lin_count;
	} tri_t;

	typedef struct packed {
		logic        enable;
		logic        short_mode;
		logic        run;
		logic [14:0] lfsr;
		logic [7:0]  length;
		logic [11:0] period;
		logic [11:0] timer;
		env_t        env;
	} noise_t;

	typedef struct packed {
		pulse_t [1:0] pulse;
		tri_t         triangle;
		noise_t       noise;
		logic [1:0]   frame_step;
	} apu_state_t;

	// Channel levels handed to the mixer.
	typedef struct packed {
		logic [3:0] p1;
		logic [3:0] p2;
		logic [3:0] triangle;
		logic [3:0] noise;
	} levels_t;

	// Fixed point floor(n / d) with FRAC_BITS fraction bits, by restoring division.
	function automatic frac_t fix_div(logic [63:0] n, longint unsigned d);
		longint unsigned r;
		logic [87:0] q;
		r = 0;
		q = '0;
		for (int i = 87; i >= 0; i--) begin
			r = (r << 1) | ((i >= FRAC_BITS) ? longint'(n[i - FRAC_BITS]) : 0);
			q = q << 1;
			if (r >= d) begin
				r = r - d;
				q[0] = 1'b1;
			end
		end
		return q[31:0];
	endfunction

	// Pulse part of the mix, indexed by the sum of both pulse levels.
	function automatic pmix_tab_t build_pmix();
		pmix_tab_t t;
		longint unsigned s;
		for (int i = 0; i < 31; i++) begin
			s = longint'(i);
			t[i] = fix_div(64'(255 * 9552 * s), 100 * (8128 + 100 * s));
		end
		return t;
	endfunction

	// Triangle and noise part of the mix, indexed by {triangle, noise}.
	function automatic tmix_tab_t build_tmix();
		tmix_tab_t t;
		longint unsigned m;
		for (int i = 0; i < 256; i++) begin
			m = 12241 * longint'(i / 16) + 8227 * longint'(i % 16);
			t[i] = fix_div(64'(255 * 16367 * m), 100 * (100706707 + 100 * m));
		end
		return t;
	endfunction

endpackage
`default_nettype wire

@@ hdl/stn_core.sv @@
`default_nettype none
module stn_core
	import stn_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        go,
	input  wire logic [1:0]  kind,
	input  wire logic [15:0] reg_address,
	input  wire logic [7:0]  write_data,
	output levels_t          levels
);

	apu_state_t st_q;
	apu_state_t ns;

	function automatic env_t env_step(env_t e);
		env_t r;
		r = e;
		if (e.start) begin
			r.vol = 4'd15;
			r.div = e.period;
			r.start = 1'b0;
		end else if (e.div != 4'd0) begin
			r.div = e.div - 4'd1;
		end else begin
			if (e.vol != 4'd0) r.vol = e.vol - 4'd1;
			else if (e.loop) r.vol = 4'd15;
			r.div = e.period;
		end
		return r;
	endfunction

	function automatic logic [15:0] sweep_target(pulse_t p, logic first);
		logic [15:0] d;
		d = p.period >> p.sw_shift;
		if (p.sw_neg) return p.period - d - {15'd0, first};
		return p.period + d;
	endfunction

	function automatic pulse_t pulse_sweep(pulse_t p, logic first);
		pulse_t r;
		r = p;
		if (p.sw_reload) begin
			if (p.sw_on && p.sw_div == 4'd0) r.period = sweep_target(p, first);
			r.sw_div = p.sw_period;
			r.sw_reload = 1'b0;
		end else if (p.sw_div != 4'd0) begin
			r.sw_div = p.sw_div - 4'd1;
		end else begin
			if (p.sw_on) r.period = sweep_target(p, first);
			r.sw_div = p.sw_period;
		end
		return r;
	endfunction

	function automatic apu_state_t quarter(apu_state_t s);
		apu_state_t r;
		r = s;
		r.pulse[0].env = env_step(s.pulse[0].env);
		r.pulse[1].env = env_step(s.pulse[1].env);
		if (s.triangle.reload_flag) r.triangle.lin_count = s.triangle.lin_reload;
		else if (s.triangle.lin_count != 7'd0)
			r.triangle.lin_count = s.triangle.lin_count - 7'd1;
		r.triangle.reload_flag = 1'b0;
		r.noise.env = env_step(s.noise.env);
		return r;
	endfunction

	function automatic apu_state_t half(apu_state_t s);
		apu_state_t r;
		r = s;
		r.pulse[0] = pulse_sweep(s.pulse[0], 1'b1);
		r.pulse[1] = pulse_sweep(s.pulse[1], 1'b0);
		for (int i = 0; i < 2; i++) begin
			if (r.pulse[i].run && r.pulse[i].length != 8'd0)
				r.pulse[i].length = r.pulse[i].length - 8'd1;
		end
		if (s.triangle.run && s.triangle.length != 8'd0)
			r.triangle.length = s.triangle.length - 8'd1;
		if (s.noise.run && s.noise.length != 8'd0)
			r.noise.length = s.noise.length - 8'd1;
		return r;
	endfunction

	function automatic apu_state_t tick(apu_state_t s);
		apu_state_t r;
		logic fb;
		r = s;
		for (int i = 0; i < 2; i++) begin
			if (s.pulse[i].timer == 16'd0) begin
				r.pulse[i].timer = s.pulse[i].period;
				r.pulse[i].duty_step = s.pulse[i].duty_step + 3'd1;
			end else begin
				r.pulse[i].timer = s.pulse[i].timer - 16'd1;
			end
		end
		if (s.triangle.timer == 11'd0) begin
			r.triangle.timer = s.triangle.period;
			if (s.triangle.length != 8'd0 && s.triangle.lin_count != 7'd0)
				r.triangle.step = s.triangle.step + 5'd1;
		end else begin
			r.triangle.timer = s.triangle.timer - 11'd1;
		end
		fb = s.noise.lfsr[0] ^ (s.noise.short_mode ? s.noise.lfsr[6] : s.noise.lfsr[1]);
		if (s.noise.timer == 12'd0) begin
			r.noise.timer = s.noise.period;
			r.noise.lfsr = {fb, s.noise.lfsr[14:1]};
		end else begin
			r.noise.timer = s.noise.timer - 12'd1;
		end
		return r;
	endfunction

	function automatic pulse_t pulse_write(pulse_t p, logic [1:0] sel, logic [7:0] v);
		pulse_t r;
		r = p;
		unique case (sel)
			PREG_CTL: begin
				r.duty_mode = v[7:6];
				r.run = ~v[5];
				r.env.loop = v[5];
				r.env.on = ~v[4];
				r.env.period = v[3:0];
				r.env.start = 1'b1;
			end
			PREG_SWEEP: begin
				r.sw_on = v[7];
				r.sw_period = {1'b0, v[6:4]} + 4'd1;
				r.sw_neg = v[3];
				r.sw_shift = v[2:0];
				r.sw_reload = 1'b1;
			end
			PREG_LO: r.period = {p.period[15:8], v};
			PREG_HI: begin
				r.length = LEN_TAB[v[7:3]];
				r.period = {5'd0, v[2:0], p.period[7:0]};
				r.env.start = 1'b1;
				r.duty_step = 3'd0;
			end
			default: r = p;
		endcase
		return r;
	endfunction

	function automatic apu_state_t reg_write(apu_state_t s, logic [15:0] a, logic [7:0] v);
		apu_state_t r;
		r = s;
		if (a >= ADDR_PULSE_LO && a <= ADDR_PULSE_HI) begin
			r.pulse[a[2]] = pulse_write(s.pulse[a[2]], a[1:0], v);
		end else begin
			unique case (a)
				ADDR_TRI_LIN: begin
					r.triangle.run = ~v[7];
					r.triangle.lin_reload = v[6:0];
				end
				ADDR_TRI_LO: r.triangle.period = {s.triangle.period[10:8], v};
				ADDR_TRI_HI: begin
					r.triangle.length = LEN_TAB[v[7:3]];
					r.triangle.period = {v[2:0], s.triangle.period[7:0]};
					r.triangle.timer = {v[2:0], s.triangle.period[7:0]};
					r.triangle.reload_flag = 1'b1;
				end
				ADDR_NOI_CTL: begin
					r.noise.run = ~v[5];
					r.noise.env.loop = v[5];
					r.noise.env.on = ~v[4];
					r.noise.env.period = v[3:0];
					r.noise.env.start = 1'b1;
				end
				ADDR_NOI_PER: begin
					r.noise.short_mode = v[7];
					r.noise.period = NOISE_TAB[v[3:0]];
				end
				ADDR_NOI_LEN: begin
					r.noise.length = LEN_TAB[v[7:3]];
					r.noise.env.start = 1'b1;
				end
				ADDR_STATUS: begin
					r.pulse[0].enable = v[0];
					r.pulse[1].enable = v[1];
					r.triangle.enable = v[2];
					r.noise.enable = v[3];
					if (!v[0]) r.pulse[0].length = 8'd0;
					if (!v[1]) r.pulse[1].length = 8'd0;
					if (!v[2]) r.triangle.length = 8'd0;
					if (!v[3]) r.noise.length = 8'd0;
				end
				ADDR_FRAME: if (v[7]) r = half(quarter(s));
				default: r = s;
			endcase
		end
		return r;
	endfunction

	function automatic logic [3:0] pulse_level(pulse_t p, logic first);
		logic [7:0] duty;
		duty = DUTY_TAB[p.duty_mode];
		if (!p.enable || p.length == 8'd0) return 4'd0;
		if (!duty[p.duty_step]) return 4'd0;
		if (p.period < 16'd8 || p.period > PERIOD_MAX) return 4'd0;
		if (p.sw_on && sweep_target(p, first) > PERIOD_MAX) return 4'd0;
		return p.env.on ? p.env.vol : p.env.period;
	endfunction

	// State after reset: everything clear except the noise shift register.
	function automatic apu_state_t reset_state();
		apu_state_t r;
		r = '0;
		r.noise.lfsr = 15'd1;
		return r;
	endfunction

	// Next state for the item in the input register.
	always_comb begin
		ns = st_q;
		if (go) begin
			unique case (kind)
				KIND_WRITE: ns = reg_write(st_q, reg_address, write_data);
				KIND_TICK:  ns = tick(st_q);
				KIND_FRAME: begin
					ns.frame_step = st_q.frame_step + 2'd1;
					ns = quarter(ns);
					if (ns.frame_step[0]) ns = half(ns);
				end
				default: ns = st_q;
			endcase
		end
	end

	// Channel levels after the item is applied.
	always_comb begin
		levels.p1 = pulse_level(ns.pulse[0], 1'b1);
		levels.p2 = pulse_level(ns.pulse[1], 1'b0);
		if (!ns.triangle.enable || ns.triangle.length == 8'd0
				|| ns.triangle.lin_count == 7'd0 || ns.triangle.period < 11'd2)
			levels.triangle = 4'd0;
		else
			levels.triangle = ns.triangle.step[4] ? ns.triangle.step[3:0]
				: 4'd15 - ns.triangle.step[3:0];
		if (!ns.noise.enable || ns.noise.length == 8'd0 || ns.noise.lfsr[0])
			levels.noise = 4'd0;
		else
			levels.noise = ns.noise.env.on ? ns.noise.env.vol : ns.noise.env.period;
	end

	// Channel state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= reset_state();
		end else begin
			st_q <= ns;
		end
	end

endmodule
`default_nettype wire

@@ hdl/stn_mix.sv @@
`default_nettype none
module stn_mix
	import stn_pkg::*;
(
	input  wire levels_t     levels,
	output logic [7:0]       sample
);

	localparam pmix_tab_t PMIX = build_pmix();
	localparam tmix_tab_t TMIX = build_tmix();

	logic [4:0]  pulse_pair;
	logic [32:0] total;

	// Sum of both fixed-point mixer terms; the integer part is the sample.
	always_comb begin
		pulse_pair = {1'b0, levels.p1} + {1'b0, levels.p2};
		total = {1'b0, PMIX[pulse_pair]} + {1'b0, TMIX[{levels.triangle, levels.noise}]};
		sample = total[FRAC_BITS +: 8];
	end

endmodule
`default_nettype wire

@@ hdl/square_triangle_noise_sound_unit.sv @@
// Sound unit with two pulse channels, a triangle channel and a noise channel.
// Input channel (in_valid / in_stall): each beat carries kind, reg_address and
// write_data. Kind 0 writes a register at 0x4000-0x4017, kind 1 is one timer
// tick for all channels, kind 2 is one frame sequencer step.
// Output channel (out_valid / out_stall): one beat per input beat, carrying the
// four channel levels and the 8-bit mixed sample after that item took effect.
// A beat in the input register is applied to the channel state at the same
// edge that loads its result into the result register, once that is free.
// One item per cycle while the receiver does not stall, with the single channel
// state update sitting between the input register and the result register.
// Reset clears all channel state (the noise shift register resets to one) and
// empties both registers. When the receiver stalls, the result is held and the
// input register still takes one more beat; after that in_stall rises until
// the result is taken.
`default_nettype none
module square_triangle_noise_sound_unit
	import stn_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  kind,
	input  wire logic [15:0] reg_address,
	input  wire logic [7:0]  write_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       mixed_sample,
	output logic [3:0]       pulse1_level,
	output logic [3:0]       pulse2_level,
	output logic [3:0]       triangle_level,
	output logic [3:0]       noise_level
);

	logic        valid_s1;
	logic [1:0]  kind_s1;
	logic [15:0] addr_s1;
	logic [7:0]  data_s1;
	logic        out_free;
	logic        go;
	levels_t     levels;
	logic [7:0]  sample;

	assign out_free = !out_valid || !out_stall;
	assign go = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1 <= kind;
			addr_s1 <= reg_address;
			data_s1 <= write_data;
		end
	end

	stn_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.go          (go),
		.kind        (kind_s1),
		.reg_address (addr_s1),
		.write_data  (data_s1),
		.levels      (levels)
	);

	stn_mix u_mix (
		.levels (levels),
		.sample (sample)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (go) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			mixed_sample   <= sample;
			pulse1_level   <= levels.p1;
			pulse2_level   <= levels.p2;
			triangle_level <= levels.triangle;
			noise_level    <= levels.noise;
		end
	end

endmodule
`default_nettype wire

@@ hdl/stn_checker.sv @@
`default_nettype none
module stn_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [7:0]  mixed_sample,
	input wire logic [3:0]  pulse1_level,
	input wire logic [3:0]  pulse2_level,
	input wire logic [3:0]  triangle_level,
	input wire logic [3:0]  noise_level
);

	// A stalled result beat stays and keeps its sample.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(mixed_sample))
		else $error("stalled result beat changed");

	// The input only stalls behind a waiting result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result waiting");

	// All channels silent gives a zero sample.
	a_silent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pulse1_level == 4'd0 && pulse2_level == 4'd0
		&& triangle_level == 4'd0 && noise_level == 4'd0 |-> mixed_sample == 8'd0)
		else $error("nonzero sample from silent channels");

	// Any sounding channel gives a nonzero sample.
	a_audible: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (pulse1_level != 4'd0 || pulse2_level != 4'd0
		|| triangle_level != 4'd0 || noise_level != 4'd0) |-> mixed_sample != 8'd0)
		else $error("zero sample from sounding channel");

endmodule

bind square_triangle_noise_sound_unit stn_checker u_stn_checker (.*);
`default_nettype wire

@@ tb/square_triangle_noise_sound_unit_checker.sv @@
`default_nettype none
module square_triangle_noise_sound_unit_checker
	import stn_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [1:0]  kind,
	input  wire logic [15:0] reg_address,
	input  wire logic [7:0]  write_data,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [7:0]  mixed_sample,
	input  wire logic [3:0]  pulse1_level,
	input  wire logic [3:0]  pulse2_level,
	input  wire logic [3:0]  triangle_level,
	input  wire logic [3:0]  noise_level,
	output int               fail_count,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [7:0] mix;
		logic [3:0] p1;
		logic [3:0] p2;
		logic [3:0] tr;
		logic [3:0] no;
	} sound_out_t;

	sound_out_t levels_due[$];

	// Predicted unit state.
	pulse_t      sq[2];
	logic        tr_enable, tr_run, tr_reload;
	logic [7:0]  tr_length;
	logic [10:0] tr_period, tr_timer;
	logic [4:0]  tr_step;
	logic [6:0]  tr_lin_reload, tr_lin_count;
	logic        nz_enable, nz_short, nz_run;
	logic [14:0] nz_lfsr;
	logic [7:0]  nz_length;
	logic [11:0] nz_period, nz_timer;
	env_t        nz_env;
	logic [1:0]  seq_step;

	function automatic logic [15:0] sweep_goal(pulse_t p, int ch);
		logic [15:0] d, t;
		d = p.period >> p.sw_shift;
		if (p.sw_neg) begin
			t = p.period - d;
			if (ch == 0)
				t = t - 16'd1;
		end else begin
			t = p.period + d;
		end
		return t;
	endfunction

	function automatic env_t clock_env(env_t e);
		if (e.start) begin
			e.vol = 4'd15;
			e.div = e.period;
			e.start = 1'b0;
		end else if (e.div > 0) begin
			e.div = e.div - 4'd1;
		end else begin
			if (e.vol > 0)
				e.vol = e.vol - 4'd1;
			else if (e.loop)
				e.vol = 4'd15;
			e.div = e.period;
		end
		return e;
	endfunction

	// Envelopes and the linear counter.
	task automatic quarter_frame();
		for (int i = 0; i < 2; i++)
			sq[i].env = clock_env(sq[i].env);
		if (tr_reload)
			tr_lin_count = tr_lin_reload;
		else if (tr_lin_count > 0)
			tr_lin_count--;
		tr_reload = 1'b0;
		nz_env = clock_env(nz_env);
	endtask

	// Sweeps and length counters.
	task automatic half_frame();
		for (int i = 0; i < 2; i++) begin
			if (sq[i].sw_reload) begin
				if (sq[i].sw_on && sq[i].sw_div == 0)
					sq[i].period = sweep_goal(sq[i], i);
				sq[i].sw_div = sq[i].sw_period;
				sq[i].sw_reload = 1'b0;
			end else if (sq[i].sw_div > 0) begin
				sq[i].sw_div--;
			end else begin
				if (sq[i].sw_on)
					sq[i].period = sweep_goal(sq[i], i);
				sq[i].sw_div = sq[i].sw_period;
			end
		end
		for (int i = 0; i < 2; i++)
			if (sq[i].run && sq[i].length > 0)
				sq[i].length--;
		if (tr_run && tr_length > 0)
			tr_length--;
		if (nz_run && nz_length > 0)
			nz_length--;
	endtask

	task automatic timer_tick();
		logic fb;
		for (int i = 0; i < 2; i++) begin
			if (sq[i].timer == 0) begin
				sq[i].timer = sq[i].period;
				sq[i].duty_step = sq[i].duty_step + 3'd1;
			end else begin
				sq[i].timer--;
			end
		end
		if (tr_timer == 0) begin
			tr_timer = tr_period;
			if (tr_length > 0 && tr_lin_count > 0)
				tr_step = tr_step + 5'd1;
		end else begin
			tr_timer--;
		end
		if (nz_timer == 0) begin
			fb = nz_lfsr[0] ^ (nz_short ? nz_lfsr[6] : nz_lfsr[1]);
			nz_timer = nz_period;
			nz_lfsr = {fb, nz_lfsr[14:1]};
		end else begin
			nz_timer--;
		end
	endtask

	task automatic bus_write(logic [15:0] a, logic [7:0] v);
		int ch;
		if (a >= ADDR_PULSE_LO && a <= ADDR_PULSE_HI) begin
			ch = a[2];
			case (a[1:0])
				PREG_CTL: begin
					sq[ch].duty_mode = v[7:6];
					sq[ch].run = !v[5];
					sq[ch].env.loop = v[5];
					sq[ch].env.on = !v[4];
					sq[ch].env.period = v[3:0];
					sq[ch].env.start = 1'b1;
				end
				PREG_SWEEP: begin
					sq[ch].sw_on = v[7];
					sq[ch].sw_period = {1'b0, v[6:4]} + 4'd1;
					sq[ch].sw_neg = v[3];
					sq[ch].sw_shift = v[2:0];
					sq[ch].sw_reload = 1'b1;
				end
				PREG_LO: sq[ch].period[7:0] = v;
				default: begin
					sq[ch].length = LEN_TAB[v[7:3]];
					sq[ch].period[15:8] = {5'd0, v[2:0]};
					sq[ch].env.start = 1'b1;
					sq[ch].duty_step = '0;
				end
			endcase
		end else begin
			case (a)
				ADDR_TRI_LIN: begin
					tr_run = !v[7];
					tr_lin_reload = v[6:0];
				end
				ADDR_TRI_LO: tr_period[7:0] = v;
				ADDR_TRI_HI: begin
					tr_length = LEN_TAB[v[7:3]];
					tr_period[10:8] = v[2:0];
					tr_timer = tr_period;
					tr_reload = 1'b1;
				end
				ADDR_NOI_CTL: begin
					nz_run = !v[5];
					nz_env.loop = v[5];
					nz_env.on = !v[4];
					nz_env.period = v[3:0];
					nz_env.start = 1'b1;
				end
				ADDR_NOI_PER: begin
					nz_short = v[7];
					nz_period = NOISE_TAB[v[3:0]];
				end
				ADDR_NOI_LEN: begin
					nz_length = LEN_TAB[v[7:3]];
					nz_env.start = 1'b1;
				end
				ADDR_STATUS: begin
					sq[0].enable = v[0];
					sq[1].enable = v[1];
					tr_enable = v[2];
					nz_enable = v[3];
					if (!v[0]) sq[0].length = '0;
					if (!v[1]) sq[1].length = '0;
					if (!v[2]) tr_length = '0;
					if (!v[3]) nz_length = '0;
				end
				ADDR_FRAME: begin
					if (v[7]) begin
						quarter_frame();
						half_frame();
					end
				end
				default: ;
			endcase
		end
	endtask

	function automatic logic [3:0] square_out(int ch);
		logic [7:0] pattern;
		pattern = DUTY_TAB[sq[ch].duty_mode];
		if (!sq[ch].enable || sq[ch].length == 0 || !pattern[sq[ch].duty_step])
			return 4'd0;
		if (sq[ch].period < 16'd8 || sq[ch].period > PERIOD_MAX)
			return 4'd0;
		if (sq[ch].sw_on && sweep_goal(sq[ch], ch) > PERIOD_MAX)
			return 4'd0;
		return sq[ch].env.on ? sq[ch].env.vol : sq[ch].env.period;
	endfunction

	// Exact rational mix, truncated.
	function automatic logic [7:0] mix_levels(int s, int t, int n);
		longint unsigned m, a, b, c, e;
		m = 12241 * t + 8227 * n;
		a = 255 * 9552 * longint'(s);
		b = 100 * (8128 + 100 * longint'(s));
		c = 255 * 16367 * m;
		e = 100 * (100706707 + 100 * m);
		return 8'((a * e + c * b) / (b * e));
	endfunction

	task automatic apply_beat(logic [1:0] k, logic [15:0] a, logic [7:0] v);
		sound_out_t r;
		case (k)
			KIND_WRITE: bus_write(a, v);
			KIND_TICK:  timer_tick();
			KIND_FRAME: begin
				seq_step = seq_step + 2'd1;
				quarter_frame();
				if (seq_step[0])
					half_frame();
			end
			default: ;
		endcase
		r.p1 = square_out(0);
		r.p2 = square_out(1);
		if (!tr_enable || tr_length == 0 || tr_lin_count == 0 || tr_period < 11'd2)
			r.tr = 4'd0;
		else
			r.tr = tr_step[4] ? tr_step[3:0] : 4'd15 - tr_step[3:0];
		if (!nz_enable || nz_length == 0 || nz_lfsr[0])
			r.no = 4'd0;
		else
			r.no = nz_env.on ? nz_env.vol : nz_env.period;
		r.mix = mix_levels(r.p1 + r.p2, r.tr, r.no);
		levels_due.push_back(r);
	endtask

	// Check the result beat first, then predict from the input beat.
	always @(posedge clk or negedge arst_n) begin
		sound_out_t x;
		if (!arst_n) begin
			sq[0] = '0;
			sq[1] = '0;
			{tr_enable, tr_run, tr_reload} = '0;
			tr_length = '0;
			tr_period = '0;
			tr_timer = '0;
			tr_step = '0;
			tr_lin_reload = '0;
			tr_lin_count = '0;
			{nz_enable, nz_short, nz_run} = '0;
			nz_lfsr = 15'd1;
			nz_length = '0;
			nz_period = '0;
			nz_timer = '0;
			nz_env = '0;
			seq_step = '0;
			levels_due.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (levels_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: result beat with nothing expected", $realtime);
				end else begin
					x = levels_due.pop_front();
					if (x.mix !== mixed_sample || x.p1 !== pulse1_level ||
							x.p2 !== pulse2_level || x.tr !== triangle_level ||
							x.no !== noise_level) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: expected mix %0d p1 %0d p2 %0d tri %0d noise %0d, got %0d %0d %0d %0d %0d",
								$realtime, x.mix, x.p1, x.p2, x.tr, x.no, mixed_sample,
								pulse1_level, pulse2_level, triangle_level, noise_level);
					end
				end
			end
			if (in_valid && !in_stall)
				apply_beat(kind, reg_address, write_data);
			pending = levels_due.size();
		end
	end

endmodule
`default_nettype wire

@@ tb/square_triangle_noise_sound_unit_tb.sv @@
`default_nettype none
module square_triangle_noise_sound_unit_tb;
	import stn_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  kind = KIND_TICK;
	logic [15:0] reg_address = '0;
	logic [7:0]  write_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  mixed_sample;
	logic [3:0]  pulse1_level, pulse2_level, triangle_level, noise_level;
	int          fail_count, pending;
	int          cycles = 0;
	logic        quiet = 1'b0;

	square_triangle_noise_sound_unit i_dut (.*);
	square_triangle_noise_sound_unit_checker i_checker (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 100000) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Receiver stalls at random, never during the quiet stretch.
	always @(negedge clk)
		out_stall <= !quiet && ($urandom_range(99) < 26);

	// Drive one beat, at random with in_valid dropped in front of it.
	task automatic send_beat(logic [1:0] k, logic [15:0] a, logic [7:0] v);
		if (!quiet && $urandom_range(99) < 35) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		reg_address <= a;
		write_data <= v;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// Mostly decoded writes, ticks and frame steps; some noise.
	task automatic random_beat();
		int r;
		logic [15:0] a;
		logic [7:0] v;
		r = $urandom_range(99);
		v = 8'($urandom);
		a = ADDR_PULSE_LO + 16'($urandom_range(23));
		if (a == ADDR_STATUS && $urandom_range(3) != 0)
			v[3:0] = 4'hf;
		if ((a == ADDR_PULSE_LO + 3 || a == ADDR_PULSE_LO + 7 || a == ADDR_TRI_HI)
				&& $urandom_range(1))
			v[2:0] = 3'd0;
		if (r < 40)
			send_beat(KIND_TICK, 16'($urandom), 8'($urandom));
		else if (r < 58)
			send_beat(KIND_FRAME, 16'($urandom), 8'($urandom));
		else if (r < 94)
			send_beat(KIND_WRITE, a, v);
		else if (r < 97)
			send_beat(KIND_WRITE, 16'($urandom), v);
		else
			send_beat(KIND_SPARE, 16'($urandom), v);
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed beats.
		send_beat(KIND_WRITE, ADDR_STATUS, 8'h0f);
		send_beat(KIND_WRITE, ADDR_PULSE_LO, 8'hbf);
		send_beat(KIND_WRITE, ADDR_PULSE_LO + 1, 8'hff);
		send_beat(KIND_WRITE, ADDR_PULSE_LO + 2, 8'h08);
		send_beat(KIND_WRITE, ADDR_PULSE_LO + 3, 8'hf8);
		send_beat(KIND_WRITE, ADDR_PULSE_LO + 4, 8'h40);
		send_beat(KIND_WRITE, ADDR_PULSE_LO + 5, 8'h80);
		send_beat(KIND_WRITE, ADDR_PULSE_LO + 6, 8'hff);
		send_beat(KIND_WRITE, ADDR_PULSE_HI, 8'h07);
		send_beat(KIND_WRITE, ADDR_TRI_LIN, 8'h7f);
		send_beat(KIND_WRITE, ADDR_TRI_LO, 8'h01);
		send_beat(KIND_WRITE, ADDR_TRI_HI, 8'h08);
		send_beat(KIND_WRITE, ADDR_NOI_CTL, 8'h1f);
		send_beat(KIND_WRITE, ADDR_NOI_PER, 8'h80);
		send_beat(KIND_WRITE, ADDR_NOI_LEN, 8'hff);
		send_beat(KIND_WRITE, ADDR_FRAME, 8'h80);
		send_beat(KIND_WRITE, ADDR_FRAME, 8'h7f);
		send_beat(KIND_WRITE, 16'h4009, 8'hff);
		send_beat(KIND_WRITE, 16'hffff, 8'h00);
		send_beat(KIND_WRITE, 16'h0000, 8'hff);
		send_beat(KIND_TICK, 16'hffff, 8'hff);
		send_beat(KIND_FRAME, 16'h0000, 8'h00);
		send_beat(KIND_SPARE, 16'h4015, 8'h00);
		send_beat(KIND_WRITE, ADDR_STATUS, 8'h00);

		// Hold off until every result has come back.
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);

		for (int i = 0; i < 450; i++) begin
			quiet <= (i >= 150 && i < 230);
			random_beat();
		end
		in_valid <= 1'b0;
		quiet <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
`default_nettype wire
